// ===== design/bsed_pkg.sv =====
// shared types and constants of the syntax element decoder
package bsed_pkg;

  // field widths fixed by the bitstream interface
  localparam int WinW  = 64;
  localparam int OpW   = 3;
  localparam int NW    = 6;
  localparam int ValW  = 33;
  localparam int CntW  = 7;
  localparam int FixW  = 32;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_U  = 3'd0,
    OP_I  = 3'd1,
    OP_TU = 3'd2,
    OP_UE = 3'd3,
    OP_SE = 3'd4
  } op_e;

  // input transfer
  typedef struct packed {
    logic [WinW-1:0] window;
    logic [OpW-1:0]  operation;
    logic [NW-1:0]   n;
  } in_t;

  // result transfer
  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [CntW-1:0]        bits_used;
    logic                   error;
  } out_t;

  // after the bit scan: leading zero and leading one counts
  typedef struct packed {
    logic [WinW-1:0] window;
    logic [OpW-1:0]  operation;
    logic [NW-1:0]   n;
    logic [CntW-1:0] lead_zeros;
    logic [CntW-1:0] lead_ones;
  } scan_t;

  // after extraction: raw field value, length and error
  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [NW-1:0]   n;
    logic            error;
    logic [CntW-1:0] used;
    logic [ValW-1:0] raw;
  } extr_t;

endpackage

// ===== design/bitstream_syntax_element_decoder.sv =====
// top level of the syntax element decoder: input register and pipeline stages
//
//   transfer   direction  handshake                     payload
//   in         into       in_valid_i / in_stall_o       bsed_pkg::in_t  (window, operation, n)
//   out        out of     out_valid_o / out_stall_i     bsed_pkg::out_t (value, bits_used, error)
//
// one element per cycle sustained while the output does not stall; four register stages
// (input register, bit scan, extraction, sign and result register), which each element
// passes through in that order before its result is offered on the out transfer
// the bit scan priority encoder and the extraction shifters set the stage depth
// reset clears only the stage valid bits; the payload registers are not reset
// a stall freezes occupied stages back to the first empty stage, which keeps filling

module bitstream_syntax_element_decoder #(
  parameter int WINDOW_BITS    = 64,
  parameter int MAX_FIXED_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bsed_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bsed_pkg::out_t out_data_o
);

  logic            in_valid_q;
  bsed_pkg::in_t   in_data_q;
  logic            scan_valid, scan_stall;
  bsed_pkg::scan_t scan_data;
  logic            extr_valid, extr_stall;
  bsed_pkg::extr_t extr_data;
  logic            fin_stall;

  assign in_stall_o = in_valid_q && scan_stall;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  bsed_scan #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .stall_o (scan_stall),
    .data_i  (in_data_q),
    .valid_o (scan_valid),
    .stall_i (extr_stall),
    .data_o  (scan_data)
  );

  bsed_extract #(
    .WINDOW_BITS   (WINDOW_BITS),
    .MAX_FIXED_BITS(MAX_FIXED_BITS)
  ) u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scan_valid),
    .stall_o (extr_stall),
    .data_i  (scan_data),
    .valid_o (extr_valid),
    .stall_i (fin_stall),
    .data_o  (extr_data)
  );

  bsed_finish #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (extr_valid),
    .stall_o (fin_stall),
    .data_i  (extr_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== design/bsed_scan.sv =====
// stage two: leading zero and leading one counts over the window
module bsed_scan #(
  parameter int WINDOW_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  bsed_pkg::in_t  data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output bsed_pkg::scan_t data_o
);

  localparam int Msb = bsed_pkg::WinW - 1;

  logic            valid_q;
  bsed_pkg::scan_t data_q, data_d;
  logic [bsed_pkg::CntW-1:0] lz, lo;

  // priority encoders, count saturates at the window size
  always_comb begin
    lz = bsed_pkg::CntW'(WINDOW_BITS);
    lo = bsed_pkg::CntW'(WINDOW_BITS);
    for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
      if (data_i.window[Msb - i]) begin
        lz = bsed_pkg::CntW'(i);
      end else begin
        lo = bsed_pkg::CntW'(i);
      end
    end
  end

  always_comb begin
    data_d.window     = data_i.window;
    data_d.operation  = data_i.operation;
    data_d.n          = data_i.n;
    data_d.lead_zeros = lz;
    data_d.lead_ones  = lo;
  end

  assign stall_o = valid_q && stall_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/bsed_extract.sv =====
// stage three: field extraction, length and error checks
module bsed_extract #(
  parameter int WINDOW_BITS    = 64,
  parameter int MAX_FIXED_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  bsed_pkg::scan_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output bsed_pkg::extr_t data_o
);

  localparam int CntW = bsed_pkg::CntW;
  localparam int ValW = bsed_pkg::ValW;
  localparam int WinW = bsed_pkg::WinW;

  logic            valid_q;
  bsed_pkg::extr_t data_q, data_d;

  logic [CntW-1:0] n_ext, win_cnt, fix_sh;
  logic [CntW:0]   eg_len, eg_sh;
  logic [WinW-1:0] fix_word, eg_word;
  logic            n_bad, tu_over, eg_bad;
  logic [CntW-1:0] tu_val, tu_used;

  always_comb begin
    n_ext   = CntW'(data_i.n);
    win_cnt = CntW'(WINDOW_BITS);
    // fixed-width field sits in the top n bits
    fix_sh   = CntW'(WinW) - n_ext;
    fix_word = data_i.window >> fix_sh;
    // exp-golomb: top 2L+1 bits read as an integer give codeNum + 1
    eg_len  = {data_i.lead_zeros, 1'b1};
    eg_sh   = (CntW + 1)'(WinW) - eg_len;
    eg_word = data_i.window >> eg_sh;
    n_bad   = (data_i.n == '0) || (data_i.n > bsed_pkg::NW'(MAX_FIXED_BITS));
    eg_bad  = (data_i.lead_zeros >= win_cnt) || (eg_len > (CntW + 1)'(WINDOW_BITS));
    // truncated unary stops at the first zero or at n
    tu_over = (data_i.lead_ones < n_ext) && (data_i.lead_ones == win_cnt);
    if (data_i.lead_ones < n_ext) begin
      tu_val  = data_i.lead_ones;
      tu_used = data_i.lead_ones + CntW'(1);
    end else begin
      tu_val  = n_ext;
      tu_used = n_ext;
    end
  end

  // per-operation selection
  always_comb begin
    data_d.operation = data_i.operation;
    data_d.n         = data_i.n;
    data_d.error     = 1'b1;
    data_d.used      = '0;
    data_d.raw       = '0;
    unique case (data_i.operation) inside
      bsed_pkg::OP_U, bsed_pkg::OP_I: begin
        data_d.error = n_bad || (n_ext > win_cnt);
        data_d.used  = n_ext;
        data_d.raw   = ValW'(fix_word[bsed_pkg::FixW-1:0]);
      end
      bsed_pkg::OP_TU: begin
        data_d.error = n_bad || tu_over;
        data_d.used  = tu_used;
        data_d.raw   = ValW'(tu_val);
      end
      bsed_pkg::OP_UE, bsed_pkg::OP_SE: begin
        data_d.error = eg_bad;
        data_d.used  = eg_len[CntW-1:0];
        data_d.raw   = eg_word[ValW-1:0];
      end
      default: begin
        data_d.error = 1'b1;
      end
    endcase
  end

  assign stall_o = valid_q && stall_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/bsed_finish.sv =====
// stage four: sign handling, error zeroing and result register
module bsed_finish #(
  parameter int WINDOW_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  bsed_pkg::extr_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output bsed_pkg::out_t  data_o
);

  localparam int ValW = bsed_pkg::ValW;
  localparam int NW   = bsed_pkg::NW;

  logic                valid_q;
  bsed_pkg::out_t      data_q, data_d;
  logic [bsed_pkg::OpW-1:0] op_q;
  logic [ValW-1:0]     val, ext_mask, mag;
  logic                sign_bit;

  always_comb begin
    sign_bit = data_i.raw[NW'(data_i.n - NW'(1))];
    ext_mask = ~((ValW'(1) << data_i.n) - ValW'(1));
    mag      = data_i.raw >> 1;
    val      = '0;
    unique case (data_i.operation)
      bsed_pkg::OP_U:  val = data_i.raw;
      bsed_pkg::OP_I:  val = sign_bit ? (data_i.raw | ext_mask) : data_i.raw;
      bsed_pkg::OP_TU: val = data_i.raw;
      bsed_pkg::OP_UE: val = data_i.raw - ValW'(1);
      // even codeNum + 1 means odd codeNum, which maps to a positive value
      bsed_pkg::OP_SE: val = data_i.raw[0] ? (ValW'(0) - mag) : mag;
      default:         val = '0;
    endcase
  end

  // error results carry zero value and zero length
  always_comb begin
    data_d.error     = data_i.error;
    data_d.value     = data_i.error ? '0 : $signed(val);
    data_d.bits_used = data_i.error ? '0 : data_i.used;
  end

  assign stall_o = valid_q && stall_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
      op_q   <= data_i.operation;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // checks on the result register
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.error |-> data_q.value == '0 && data_q.bits_used == '0)
    else $error("error result with nonzero fields");

  a_eg_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.error && (op_q == bsed_pkg::OP_UE || op_q == bsed_pkg::OP_SE)
    |-> data_q.bits_used[0])
    else $error("exp-golomb length is even");

  a_used_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.error
    |-> data_q.bits_used <= bsed_pkg::CntW'(WINDOW_BITS) && data_q.bits_used != '0)
    else $error("consumed length outside the window");

endmodule

// ===== test/tb_top.sv =====
// testbench for the syntax element decoder: directed and random elements against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WindowBits         = 64;
  localparam int MaxFixedBits       = 32;
  localparam int BackpressureCycles = 60;
  localparam int DrainCycles        = 8;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  logic in_stall;
  bsed_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall  = 1'b0;
  bsed_pkg::out_t out_data;

  // results still owed by the block, oldest first
  bsed_pkg::out_t predicted_elements[$];

  bit          idle_on;
  bit          hold_req;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned mismatch_count;
  int unsigned flagged_count;
  int unsigned op_count[8];

  bitstream_syntax_element_decoder #(
    .WINDOW_BITS   (WindowBits),
    .MAX_FIXED_BITS(MaxFixedBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #1 clk_i = ~clk_i;

  // expected result of one element, error results carry zero value and length
  function automatic bsed_pkg::out_t decode_element(bsed_pkg::in_t item);
    bsed_pkg::out_t r;
    logic [63:0]    w;
    logic [63:0]    v;
    logic [63:0]    code;
    logic [63:0]    mag;
    int unsigned    n;
    int unsigned    lz;
    int unsigned    k;
    r = '0;
    w = item.window;
    n = 32'(item.n);
    case (item.operation)
      bsed_pkg::OP_U, bsed_pkg::OP_I, bsed_pkg::OP_TU: begin
        if (n == 0 || n > MaxFixedBits) begin
          r.error = 1'b1;
        end else if (item.operation == bsed_pkg::OP_TU) begin
          // count ones up to the limit, the terminating zero is consumed
          k = 0;
          while (k < n && k < WindowBits && w[bsed_pkg::WinW-1-k]) k++;
          if (k < n && k >= WindowBits) begin
            r.error = 1'b1;
          end else begin
            r.value     = bsed_pkg::ValW'(k);
            r.bits_used = bsed_pkg::CntW'((k < n) ? k + 1 : n);
          end
        end else if (n > WindowBits) begin
          r.error = 1'b1;
        end else begin
          v = w >> (bsed_pkg::WinW - n);
          if (item.operation == bsed_pkg::OP_I && v[n-1]) v = v - (64'd1 << n);
          r.value     = v[bsed_pkg::ValW-1:0];
          r.bits_used = bsed_pkg::CntW'(n);
        end
      end
      bsed_pkg::OP_UE, bsed_pkg::OP_SE: begin
        // leading zeros, a one, then as many suffix bits as zeros
        lz = 0;
        while (lz < WindowBits && !w[bsed_pkg::WinW-1-lz]) lz++;
        if (lz >= WindowBits || 2 * lz + 1 > WindowBits) begin
          r.error = 1'b1;
        end else begin
          code = (64'd1 << lz) - 64'd1;
          if (lz != 0) code = code + ((w << (lz + 1)) >> (bsed_pkg::WinW - lz));
          if (item.operation == bsed_pkg::OP_UE) begin
            r.value = code[bsed_pkg::ValW-1:0];
          end else begin
            mag     = (code + 64'd1) >> 1;
            v       = code[0] ? mag : 64'd0 - mag;
            r.value = v[bsed_pkg::ValW-1:0];
          end
          r.bits_used = bsed_pkg::CntW'(2 * lz + 1);
        end
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic bsed_pkg::in_t element(logic [63:0] w, logic [bsed_pkg::OpW-1:0] op,
                                            logic [bsed_pkg::NW-1:0] n);
    bsed_pkg::in_t item;
    item.window    = w;
    item.operation = op;
    item.n         = n;
    return item;
  endfunction

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // run of equal leading bits, the opposite bit, then noise
  function automatic logic [63:0] prefix_window(int unsigned lead, bit ones,
                                                logic [63:0] noise);
    logic [63:0] w;
    if (lead >= bsed_pkg::WinW) return ones ? '1 : '0;
    w = noise >> (lead + 1);
    w[bsed_pkg::WinW-1-lead] = ~ones;
    if (ones && lead != 0) w = w | ~({bsed_pkg::WinW{1'b1}} >> lead);
    return w;
  endfunction

  // well-formed codewords with random content, plus bad n, overlong exp-golomb prefixes and unused codes
  function automatic bsed_pkg::in_t random_element();
    bsed_pkg::in_t item;
    logic [63:0]   noise;
    int unsigned   pick;
    int unsigned   lead;
    noise = {$urandom, $urandom};
    pick  = $urandom_range(0, 99);
    item  = element(noise, bsed_pkg::OP_U, bsed_pkg::NW'($urandom_range(1, MaxFixedBits)));
    if (pick < 6) begin
      item.operation = bsed_pkg::OP_SE + bsed_pkg::OpW'($urandom_range(1, 3));
      item.n         = bsed_pkg::NW'($urandom);
    end else if (pick < 46) begin
      item.operation = (pick < 20) ? bsed_pkg::OP_U :
                       (pick < 33) ? bsed_pkg::OP_I : bsed_pkg::OP_TU;
      if (item.operation == bsed_pkg::OP_TU && $urandom_range(0, 4) != 0) begin
        item.window = prefix_window($urandom_range(0, 34), 1'b1, noise);
      end
      lead = $urandom_range(0, 19);
      if (lead == 0) item.n = '0;
      else if (lead == 1) item.n = bsed_pkg::NW'($urandom_range(MaxFixedBits + 1, 63));
    end else begin
      item.operation = (pick < 73) ? bsed_pkg::OP_UE : bsed_pkg::OP_SE;
      item.n         = bsed_pkg::NW'($urandom);
      lead           = $urandom_range(0, 19);
      if (lead < 14) lead = $urandom_range(0, 8);
      else if (lead < 19) lead = $urandom_range(9, 31);
      else lead = $urandom_range(32, 64);
      item.window = prefix_window(lead, 1'b0, noise);
    end
    return item;
  endfunction

  // offer one element and hold it until the block takes it
  task automatic send_element(input bsed_pkg::in_t item);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    predicted_elements.push_back(decode_element(item));
    sent_count++;
    op_count[item.operation]++;
  endtask

  task automatic test_fixed_width();
    idle_on = 1'b0;
    send_element(element(64'h8000_0000_0000_0000, bsed_pkg::OP_U, 6'd1));
    send_element(element(64'hFFFF_FFFF_FFFF_FFFF, bsed_pkg::OP_U, 6'd32));
    send_element(element(64'h1234_5678_9ABC_DEF0, bsed_pkg::OP_U, 6'd32));
    send_element(element(64'h8000_0000_0000_0000, bsed_pkg::OP_I, 6'd1));
    send_element(element(64'h8000_0000_FFFF_FFFF, bsed_pkg::OP_I, 6'd32));
    send_element(element(64'h7FFF_FFFF_0000_0000, bsed_pkg::OP_I, 6'd32));
  endtask

  task automatic test_truncated_unary();
    idle_on = 1'b0;
    send_element(element(64'h0000_0000_0000_0000, bsed_pkg::OP_TU, 6'd1));
    send_element(element(64'hFFFF_FFFF_FFFF_FFFF, bsed_pkg::OP_TU, 6'd1));
    send_element(element(64'hFFFF_FFFF_FFFF_FFFF, bsed_pkg::OP_TU, 6'd32));
    send_element(element(64'hFFFF_FFFE_0000_0000, bsed_pkg::OP_TU, 6'd32));
    send_element(element(64'hE000_0000_0000_0000, bsed_pkg::OP_TU, 6'd5));
  endtask

  task automatic test_exp_golomb();
    idle_on = 1'b0;
    send_element(element(64'h8000_0000_0000_0000, bsed_pkg::OP_UE, 6'd0));
    send_element(element(64'h4000_0000_0000_0000, bsed_pkg::OP_UE, 6'd63));
    send_element(element(64'h4000_0000_0000_0000, bsed_pkg::OP_SE, 6'd0));
    send_element(element(64'h6000_0000_0000_0000, bsed_pkg::OP_SE, 6'd0));
    // longest codeword that still fits: 31 zeros, one, 31 suffix bits
    send_element(element(64'h0000_0001_FFFF_FFFE, bsed_pkg::OP_UE, 6'd0));
    send_element(element(64'h0000_0001_FFFF_FFFE, bsed_pkg::OP_SE, 6'd0));
    send_element(element(64'h0000_0001_0000_0000, bsed_pkg::OP_SE, 6'd0));
  endtask

  task automatic test_error_codes();
    idle_on = 1'b0;
    // codeword one bit too long for the window, and no one bit at all
    send_element(element(64'h0000_0000_8000_0000, bsed_pkg::OP_UE, 6'd0));
    send_element(element(64'h0000_0000_0000_0000, bsed_pkg::OP_SE, 6'd0));
    send_element(element(64'hFFFF_FFFF_FFFF_FFFF, bsed_pkg::OP_U, 6'd0));
    send_element(element(64'hFFFF_FFFF_FFFF_FFFF, bsed_pkg::OP_TU, 6'd33));
    send_element(element(64'hFFFF_FFFF_FFFF_FFFF, bsed_pkg::OP_I, 6'd63));
    send_element(element(64'h8000_0000_0000_0000, bsed_pkg::OP_SE + 3'd1, 6'd1));
    send_element(element(64'h8000_0000_0000_0000, bsed_pkg::OP_SE + 3'd2, 6'd8));
    send_element(element(64'h8000_0000_0000_0000, bsed_pkg::OP_SE + 3'd3, 6'd32));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    idle_on = 1'b1;
    repeat (count) send_element(random_element());
  endtask

  task automatic test_back_to_back(input int unsigned count);
    idle_on = 1'b0;
    repeat (count) send_element(random_element());
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_element(random_element());
  endtask

  // result side: random stall, long hold on request
  initial begin : result_sink
    int unsigned stall_left;
    bit          next_stall;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      next_stall = 1'b0;
      if (stall_left != 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = BackpressureCycles - 1;
        next_stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        next_stall = 1'b1;
      end
      out_stall <= next_stall;
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin
    bsed_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (predicted_elements.size() == 0) begin
        $error("result with no element outstanding: value %0d bits_used %0d error %0b",
               out_data.value, out_data.bits_used, out_data.error);
        mismatch_count++;
      end else begin
        want = predicted_elements.pop_front();
        checked_count++;
        if (want.error) flagged_count++;
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data.value);
          mismatch_count++;
        end
        if (out_data.bits_used !== want.bits_used) begin
          $error("bits_used: expected %0d, got %0d", want.bits_used, out_data.bits_used);
          mismatch_count++;
        end
        if (out_data.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_data.error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #1_500_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fixed_width();
    test_truncated_unary();
    test_exp_golomb();
    test_error_codes();
    test_random_traffic(900);
    test_back_to_back(400);
    test_output_backpressure();
    test_random_traffic(500);

    // drain what is still in flight
    in_valid <= 1'b0;
    idle_on  = 1'b0;
    while (predicted_elements.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (predicted_elements.size() != 0) mismatch_count++;

    $display("summary: %0d elements sent: u %0d, i %0d, tu %0d, ue %0d, se %0d, unused %0d",
             sent_count, op_count[bsed_pkg::OP_U], op_count[bsed_pkg::OP_I],
             op_count[bsed_pkg::OP_TU], op_count[bsed_pkg::OP_UE],
             op_count[bsed_pkg::OP_SE],
             op_count[bsed_pkg::OP_SE + 3'd1] + op_count[bsed_pkg::OP_SE + 3'd2] +
             op_count[bsed_pkg::OP_SE + 3'd3]);
    $display("summary: %0d results checked, %0d flagged as errors, %0d mismatches",
             checked_count, flagged_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
